FILE: hw/rtl/dmle_pkg.sv
// Shared widths, codes, types and helpers for the mutual-exclusion lock engine.
// No dependencies; every other file of the block but dmle_ram imports this package.
package dmle_pkg;

  // Field widths fixed by the external message format
  localparam int CMD_W      = 3;
  localparam int LOCK_W     = 4;
  localparam int NODE_W     = 3;
  localparam int SEQ_W      = 32;
  localparam int KIND_W     = 2;
  localparam int NODE_COUNT = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Defaults for the top-level parameters
  localparam int LOCK_COUNT_DEF = 16;
  localparam int SEQ_BITS_DEF   = 32;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_INIT       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ACQUIRE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEER_REQ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEER_REPLY = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEER_MASK   = 2'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LOCK_W-1:0] lock_id;
    logic [NODE_W-1:0] from_node;
    logic [SEQ_W-1:0]  seq_number;
  } dmle_entry_t;

  typedef struct packed {
    logic [NODE_W-1:0]     own_id;
    logic [NODE_COUNT-1:0] peers;
  } dmle_cfg_t;

  // Index of the lowest set bit; 0 when none is set
  function automatic logic [NODE_W-1:0] lowest_bit(input logic [NODE_COUNT-1:0] mask);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) idx = NODE_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: hw/rtl/dmle_if.sv
// Handshake channel interfaces of the lock engine: input events, results, config.
// Depends on dmle_pkg for field widths.
interface dmle_item_if import dmle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [LOCK_W-1:0] lock_id;
  logic [NODE_W-1:0] from_node;
  logic [SEQ_W-1:0]  seq_number;

  modport source (output valid, cmd, lock_id, from_node, seq_number, input ready);
  modport sink   (input valid, cmd, lock_id, from_node, seq_number, output ready);
endinterface

interface dmle_result_if import dmle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  logic [NODE_W-1:0] to_node;
  logic [LOCK_W-1:0] out_lock;
  logic [SEQ_W-1:0]  out_seq;
  logic              last;

  modport source (output valid, out_kind, to_node, out_lock, out_seq, last, input ready);
  modport sink   (input valid, out_kind, to_node, out_lock, out_seq, last, output ready);
endinterface

interface dmle_cfg_if import dmle_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/distributed_mutex_lock_engine.sv
// One node's side of permission-based (request/deferred-reply) mutual exclusion over a
// table of LOCK_COUNT locks.
// An event is accepted into a two-entry queue whenever it has room; events with no
// effect (unknown command, lock out of range, peer traffic from a non-peer) are dropped
// before it. The back end reads the lock's state memory, then applies the event and
// updates the state, then emits its results, if any, one at a time; an acquire or
// release may address every peer. Results leave through an output register, so a
// stalled result channel holds only the back end. Lock state resets to zero through
// per-lock valid bits; there is no clearing pass. Configuration (own node id, peer
// mask) may be written only while no event is in flight.
module distributed_mutex_lock_engine import dmle_pkg::*; #(
  parameter int LOCK_COUNT = LOCK_COUNT_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  dmle_item_if.sink     items,
  dmle_result_if.source results,
  dmle_cfg_if.sink      cfg
);

  logic [NODE_W-1:0]     own_node_id;
  logic [NODE_COUNT-1:0] peer_mask;
  dmle_cfg_t             cfg_state;

  logic        q_ready;
  logic        push;
  dmle_entry_t push_entry;
  logic        pop;
  logic        head_valid;
  dmle_entry_t head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_id <= '0;
      peer_mask   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OWN_NODE_ID: own_node_id <= cfg.data[NODE_W-1:0];
        REG_PEER_MASK:   peer_mask   <= cfg.data[NODE_COUNT-1:0];
        default: begin
        end
      endcase
    end
  end

  // Drop own bit from the peer set
  assign cfg_state.own_id = own_node_id;
  assign cfg_state.peers  = peer_mask & ~(NODE_COUNT'(1) << own_node_id);

  dmle_front #(
    .LOCK_COUNT (LOCK_COUNT)
  ) u_front (
    .items      (items),
    .cfg        (cfg_state),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  dmle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dmle_back #(
    .LOCK_COUNT (LOCK_COUNT),
    .SEQ_BITS   (SEQ_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_state),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .results    (results)
  );

endmodule

FILE: hw/rtl/dmle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/dmle_front.sv
// Front end: accepts input events, drops the ones that have no effect, forwards the rest.
// Depends on dmle_pkg and dmle_if.
module dmle_front import dmle_pkg::*; #(
  parameter int LOCK_COUNT = LOCK_COUNT_DEF
) (
  dmle_item_if.sink   items,
  input  dmle_cfg_t   cfg,
  input  logic        q_ready,
  output logic        push,
  output dmle_entry_t push_entry
);

  logic in_range;
  logic known_cmd;
  logic peer_ok;
  logic keep;

  always_comb begin
    in_range  = 9'(items.lock_id) < 9'(LOCK_COUNT);
    known_cmd = items.cmd <= CMD_PEER_REPLY;
    // Peer traffic only counts from a node in the current peer set
    peer_ok   = 1'b1;
    if (items.cmd inside {CMD_PEER_REQ, CMD_PEER_REPLY}) begin
      peer_ok = cfg.peers[items.from_node];
    end
    keep = in_range && known_cmd && peer_ok;
  end

  assign items.ready = q_ready;
  assign push        = items.valid && q_ready && keep;

  assign push_entry.cmd        = items.cmd;
  assign push_entry.lock_id    = items.lock_id;
  assign push_entry.from_node  = items.from_node;
  assign push_entry.seq_number = items.seq_number;

endmodule

FILE: hw/rtl/dmle_queue.sv
// Short queue of classified events between the front and the back end.
// Depends on dmle_pkg for the entry type and depth.
module dmle_queue import dmle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  dmle_entry_t push_entry,
  output logic        q_ready,
  input  logic        pop,
  output logic        head_valid,
  output dmle_entry_t head
);

  localparam int QAW   = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dmle_entry_t       slots [QUEUE_DEPTH];
  logic [QAW-1:0]    wr_ptr;
  logic [QAW-1:0]    rd_ptr;
  logic [CNT_W-1:0]  count;

  assign q_ready    = count != CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/dmle_back.sv
// Back end: read-modify-write of the per-lock state and serial emission of results.
// Depends on dmle_pkg, dmle_if and dmle_ram.
module dmle_back import dmle_pkg::*; #(
  parameter int LOCK_COUNT = LOCK_COUNT_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  dmle_cfg_t     cfg,
  input  logic          head_valid,
  input  dmle_entry_t   head,
  output logic          pop,
  dmle_result_if.source results
);

  localparam int LOCK_AW = LOCK_COUNT > 1 ? $clog2(LOCK_COUNT) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  typedef struct packed {
    logic [SEQ_BITS-1:0]   own_seq;
    logic [SEQ_BITS-1:0]   high_seq;
    logic                  req;
    logic                  hold;
    logic [NODE_COUNT-1:0] replied;
    logic [NODE_COUNT-1:0] deferred;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  logic [1:0]            state;
  dmle_entry_t           item;
  logic [LOCK_COUNT-1:0] valid_bits;
  logic [REC_W-1:0]      rd_data;
  logic [LOCK_AW-1:0]    lock_idx;

  rec_t                  cur;
  rec_t                  rec_next;
  logic [NODE_COUNT-1:0] mask_next;
  logic [KIND_W-1:0]     kind_next;
  logic                  clr_valid;
  logic                  wr_en;
  logic [SEQ_BITS-1:0]   seq_in;
  logic [NODE_COUNT-1:0] fbit;
  logic [NODE_COUNT-1:0] replied_new;
  logic                  defer;

  logic [NODE_COUNT-1:0] emit_mask;
  logic [KIND_W-1:0]     emit_kind;
  logic [SEQ_BITS-1:0]   emit_seq;
  logic [NODE_W-1:0]     emit_idx;
  logic [NODE_COUNT-1:0] mask_rest;
  logic                  out_free;
  logic                  load;

  logic                  out_valid;
  logic [KIND_W-1:0]     out_kind;
  logic [NODE_W-1:0]     to_node;
  logic [LOCK_W-1:0]     out_lock;
  logic [SEQ_W-1:0]      out_seq;
  logic                  out_last;

  assign pop      = (state == S_IDLE) && head_valid;
  assign lock_idx = LOCK_AW'(item.lock_id);

  dmle_ram #(
    .WIDTH (REC_W),
    .DEPTH (LOCK_COUNT)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lock_idx),
    .wr_data (rec_next),
    .rd_en   (pop),
    .rd_addr (LOCK_AW'(head.lock_id)),
    .rd_data (rd_data)
  );

  // Apply the event to the lock's state
  always_comb begin
    cur         = valid_bits[lock_idx] ? rec_t'(rd_data) : '0;
    rec_next    = cur;
    mask_next   = '0;
    kind_next   = KIND_REPLY;
    clr_valid   = 1'b0;
    seq_in      = SEQ_BITS'(item.seq_number);
    fbit        = NODE_COUNT'(1) << item.from_node;
    replied_new = cur.replied | fbit;
    defer       = cur.hold ||
                  (cur.req && ((seq_in > cur.own_seq) ||
                               ((seq_in == cur.own_seq) && (item.from_node > cfg.own_id))));
    case (item.cmd)
      CMD_INIT: begin
        clr_valid = 1'b1;
      end
      CMD_ACQUIRE: begin
        if (!(cur.req || cur.hold)) begin
          rec_next.own_seq = (&cur.high_seq) ? cur.high_seq : cur.high_seq + 1'b1;
          rec_next.replied = '0;
          if (cfg.peers == '0) begin
            rec_next.hold = 1'b1;
            mask_next     = NODE_COUNT'(1);
            kind_next     = KIND_GRANT;
          end else begin
            rec_next.req = 1'b1;
            mask_next    = cfg.peers;
            kind_next    = KIND_REQUEST;
          end
        end
      end
      CMD_RELEASE: begin
        mask_next         = cur.deferred;
        rec_next.hold     = 1'b0;
        rec_next.req      = 1'b0;
        rec_next.replied  = '0;
        rec_next.deferred = '0;
      end
      CMD_PEER_REQ: begin
        if (seq_in > cur.high_seq) rec_next.high_seq = seq_in;
        if (defer) rec_next.deferred = cur.deferred | fbit;
        else mask_next = fbit;
      end
      CMD_PEER_REPLY: begin
        if (cur.req) begin
          rec_next.replied = replied_new;
          if ((replied_new & cfg.peers) == cfg.peers) begin
            rec_next.req  = 1'b0;
            rec_next.hold = 1'b1;
            mask_next     = NODE_COUNT'(1);
            kind_next     = KIND_GRANT;
          end
        end
      end
      default: begin
      end
    endcase
    wr_en = (state == S_EXEC) && !clr_valid;
  end

  assign emit_idx  = lowest_bit(emit_mask);
  assign mask_rest = emit_mask & ~(NODE_COUNT'(1) << emit_idx);
  assign out_free  = !out_valid || results.ready;
  assign load      = (state == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (pop) item <= head;
    if (state == S_EXEC) begin
      emit_mask <= mask_next;
      emit_kind <= kind_next;
      emit_seq  <= rec_next.own_seq;
    end else if (load) begin
      emit_mask <= mask_rest;
    end
    if (load) begin
      out_kind <= emit_kind;
      to_node  <= (emit_kind == KIND_GRANT) ? '0 : emit_idx;
      out_lock <= item.lock_id;
      out_seq  <= (emit_kind == KIND_REQUEST) ? SEQ_W'(emit_seq) : '0;
      out_last <= mask_rest == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) state <= S_EXEC;
        end
        S_EXEC: begin
          if (clr_valid) valid_bits[lock_idx] <= 1'b0;
          else valid_bits[lock_idx] <= 1'b1;
          state <= (mask_next != '0) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (load && mask_rest == '0) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

  assign results.valid    = out_valid;
  assign results.out_kind = out_kind;
  assign results.to_node  = to_node;
  assign results.out_lock = out_lock;
  assign results.out_seq  = out_seq;
  assign results.last     = out_last;

  a_emit_mask_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (emit_mask != '0))
    else $error("emission state entered with no results pending");

  a_no_req_and_hold: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !(rec_next.req && rec_next.hold))
    else $error("lock written as both requesting and holding");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_EXEC))
    else $error("state read not followed by update");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> results.valid)
    else $error("loaded result not presented");

  a_grant_single: assert property (@(posedge clk) disable iff (rst)
    (load && emit_kind == KIND_GRANT) |-> (mask_rest == '0))
    else $error("grant not the only result of its event");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for distributed_mutex_lock_engine: a directed table, then
// random acquire/reply/release rounds under random stalls, checked against a predictor.
// Depends on dmle_pkg and the handshake interfaces in dmle_if.
module tb import dmle_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOCKS         = LOCK_COUNT_DEF;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 24;
  localparam int ITEM_TARGET   = 200;
  localparam int PHASE_ITEMS   = 40;

  localparam logic [SEQ_W-1:0] SEQ_TOP       = '1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef enum {ROW_CFG, ROW_PRED, ROW_NONE, ROW_ONE} row_kind_t;

  typedef struct {
    row_kind_t             mode;
    dmle_entry_t           ev;
    logic [KIND_W-1:0]     kind;
    logic [NODE_W-1:0]     dst;
    logic [NODE_W-1:0]     id;
    logic [NODE_COUNT-1:0] mask;
  } stim_row_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] dst;
    logic [LOCK_W-1:0] lk;
    logic [SEQ_W-1:0]  seq;
    logic              last;
  } lock_msg_t;

  logic clk;
  logic rst;

  int  cycle_count = 0;
  int  fail_count = 0;
  int  sent_items = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  lock_msg_t expected_results[$];
  lock_msg_t event_msgs[$];

  // Predicted per-lock state and configuration
  logic [SEQ_W-1:0]      own_seq       [LOCKS];
  logic [SEQ_W-1:0]      seen_seq      [LOCKS];
  bit                    is_requesting [LOCKS];
  bit                    is_holding    [LOCKS];
  logic [NODE_COUNT-1:0] replied_mask  [LOCKS];
  logic [NODE_COUNT-1:0] deferred_mask [LOCKS];
  logic [NODE_W-1:0]     node_id;
  logic [NODE_COUNT-1:0] member_mask;

  dmle_item_if   item_bus ();
  dmle_result_if result_bus ();
  dmle_cfg_if    cfg_bus ();

  distributed_mutex_lock_engine uut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_bus),
    .results (result_bus),
    .cfg     (cfg_bus)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [NODE_COUNT-1:0] peer_set();
    return member_mask & ~(NODE_COUNT'(1) << node_id);
  endfunction

  function automatic void clear_lock(int l);
    own_seq[l]       = '0;
    seen_seq[l]      = '0;
    is_requesting[l] = 1'b0;
    is_holding[l]    = 1'b0;
    replied_mask[l]  = '0;
    deferred_mask[l] = '0;
  endfunction

  function automatic void add_msg(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] dst,
                                  logic [LOCK_W-1:0] lk, logic [SEQ_W-1:0] seq);
    lock_msg_t m;
    m.kind = kind;
    m.dst  = dst;
    m.lk   = lk;
    m.seq  = seq;
    m.last = 1'b0;
    event_msgs = {event_msgs, m};
  endfunction

  // Work out the messages one event causes and advance the predicted lock state
  function automatic void predict_lock_event(dmle_entry_t ev);
    logic [NODE_COUNT-1:0] peers;
    logic [NODE_COUNT-1:0] fbit;
    int l;
    peers = peer_set();
    fbit  = NODE_COUNT'(1) << ev.from_node;
    l     = ev.lock_id;
    event_msgs.delete();
    case (ev.cmd)
      CMD_INIT: clear_lock(l);
      CMD_ACQUIRE: begin
        if (!is_requesting[l] && !is_holding[l]) begin
          own_seq[l] = (seen_seq[l] == SEQ_TOP) ? SEQ_TOP : seen_seq[l] + 1'b1;
          replied_mask[l] = '0;
          if (peers == '0) begin
            is_holding[l] = 1'b1;
            add_msg(KIND_GRANT, '0, ev.lock_id, '0);
          end else begin
            is_requesting[l] = 1'b1;
            for (int i = 0; i < NODE_COUNT; i++)
              if (peers[i]) add_msg(KIND_REQUEST, NODE_W'(i), ev.lock_id, own_seq[l]);
          end
        end
      end
      CMD_RELEASE: begin
        for (int i = 0; i < NODE_COUNT; i++)
          if (deferred_mask[l][i]) add_msg(KIND_REPLY, NODE_W'(i), ev.lock_id, '0);
        is_holding[l]    = 1'b0;
        is_requesting[l] = 1'b0;
        replied_mask[l]  = '0;
        deferred_mask[l] = '0;
      end
      CMD_PEER_REQ: begin
        if ((peers & fbit) != '0) begin
          if (ev.seq_number > seen_seq[l]) seen_seq[l] = ev.seq_number;
          // defer while holding, or while our own request has priority
          if (is_holding[l] ||
              (is_requesting[l] &&
               (ev.seq_number > own_seq[l] ||
                (ev.seq_number == own_seq[l] && ev.from_node > node_id))))
            deferred_mask[l] = deferred_mask[l] | fbit;
          else
            add_msg(KIND_REPLY, ev.from_node, ev.lock_id, '0);
        end
      end
      CMD_PEER_REPLY: begin
        if ((peers & fbit) != '0 && is_requesting[l]) begin
          replied_mask[l] = replied_mask[l] | fbit;
          if ((replied_mask[l] & peers) == peers) begin
            is_requesting[l] = 1'b0;
            is_holding[l]    = 1'b1;
            add_msg(KIND_GRANT, '0, ev.lock_id, '0);
          end
        end
      end
      default: ;
    endcase
    if (event_msgs.size() > 0) event_msgs[event_msgs.size() - 1].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [LOCK_W-1:0] pick_lock();
    if ($urandom_range(0, 3) != 0) return LOCK_W'($urandom_range(0, 3));
    return LOCK_W'($urandom_range(0, LOCKS - 1));
  endfunction

  function automatic logic [NODE_W-1:0] pick_peer();
    logic [NODE_COUNT-1:0] peers;
    logic [NODE_W-1:0] n;
    peers = peer_set();
    if (peers == '0 || $urandom_range(0, 4) == 0) return NODE_W'($urandom_range(0, 7));
    do n = NODE_W'($urandom_range(0, 7)); while (!peers[n]);
    return n;
  endfunction

  // Aim near the lock's own sequence so that ties and close calls occur
  function automatic logic [SEQ_W-1:0] pick_seq(int l);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return own_seq[l] + SEQ_W'($urandom_range(0, 2)) - 1'b1;
    if (r < 6) return seen_seq[l] + 1'b1;
    if (r == 6) return SEQ_TOP;
    if (r == 7) return '0;
    return SEQ_W'($urandom);
  endfunction

  function automatic stim_row_t ev_row(row_kind_t mode, logic [CMD_W-1:0] cmd,
                                       logic [LOCK_W-1:0] lk, logic [NODE_W-1:0] src,
                                       logic [SEQ_W-1:0] seq, logic [KIND_W-1:0] kind,
                                       logic [NODE_W-1:0] dst);
    stim_row_t r;
    r.mode          = mode;
    r.ev.cmd        = cmd;
    r.ev.lock_id    = lk;
    r.ev.from_node  = src;
    r.ev.seq_number = seq;
    r.kind          = kind;
    r.dst           = dst;
    r.id            = '0;
    r.mask          = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [NODE_W-1:0] id, logic [NODE_COUNT-1:0] mask);
    stim_row_t r;
    r      = ev_row(ROW_CFG, CMD_INIT, '0, '0, '0, KIND_REQUEST, '0);
    r.id   = id;
    r.mask = mask;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  // Drive one event, wait for its transaction, then queue what it should cause
  task automatic send_item(stim_row_t row);
    int gap;
    lock_msg_t one;
    gap = pick_gap();
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.cmd        <= row.ev.cmd;
    item_bus.lock_id    <= row.ev.lock_id;
    item_bus.from_node  <= row.ev.from_node;
    item_bus.seq_number <= row.ev.seq_number;
    do @(posedge clk); while (!item_bus.ready);
    sent_items++;
    predict_lock_event(row.ev);
    if (row.mode == ROW_NONE) begin
      event_msgs.delete();
    end else if (row.mode == ROW_ONE) begin
      one.kind   = row.kind;
      one.dst    = row.dst;
      one.lk     = row.ev.lock_id;
      one.seq    = '0;
      one.last   = 1'b1;
      event_msgs = '{one};
    end
    foreach (event_msgs[i]) expected_results = {expected_results, event_msgs[i]};
  endtask

  task automatic fire(logic [CMD_W-1:0] cmd, logic [LOCK_W-1:0] lk,
                      logic [NODE_W-1:0] src, logic [SEQ_W-1:0] seq);
    send_item(ev_row(ROW_PRED, cmd, lk, src, seq, KIND_REQUEST, '0));
  endtask

  // Hold the sender until every expected result is out, then let the queue drain
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [NODE_W-1:0] id, logic [NODE_COUNT-1:0] mask);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_OWN_NODE_ID;
    cfg_bus.data  <= CFG_DATA_W'(id);
    do @(posedge clk); while (!cfg_bus.ready);
    node_id = id;
    cfg_bus.index <= REG_PEER_MASK;
    cfg_bus.data  <= mask;
    do @(posedge clk); while (!cfg_bus.ready);
    member_mask = mask;
    cfg_bus.valid <= 1'b0;
  endtask

  // One acquire with replies from the peers in random order, peer requests mixed in, then usually a release
  task automatic run_round();
    logic [NODE_COUNT-1:0] peers;
    logic [LOCK_W-1:0] lk;
    int order[$];
    int j;
    int tmp;
    peers = peer_set();
    lk    = pick_lock();
    for (int i = 0; i < NODE_COUNT; i++) if (peers[i]) order = {order, i};
    for (int i = order.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    fire(CMD_ACQUIRE, lk, NODE_W'($urandom_range(0, 7)), SEQ_W'($urandom));
    foreach (order[i]) begin
      if ($urandom_range(0, 9) < 3) fire(CMD_PEER_REQ, lk, pick_peer(), pick_seq(lk));
      // drop the rest now and then, leaving the request open
      if ($urandom_range(0, 19) == 0) break;
      fire(CMD_PEER_REPLY, lk, NODE_W'(order[i]), SEQ_W'($urandom));
    end
    if ($urandom_range(0, 1) != 0) fire(CMD_PEER_REQ, lk, pick_peer(), pick_seq(lk));
    if ($urandom_range(0, 9) < 8)
      fire(CMD_RELEASE, lk, NODE_W'($urandom_range(0, 7)), SEQ_W'($urandom));
  endtask

  task automatic send_noise();
    logic [CMD_W-1:0] cmd;
    logic [LOCK_W-1:0] lk;
    logic [NODE_W-1:0] src;
    logic [SEQ_W-1:0] seq;
    int r;
    r = $urandom_range(0, 19);
    if (r < 2)       cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    else if (r == 2) cmd = CMD_INIT;
    else if (r < 6)  cmd = CMD_ACQUIRE;
    else if (r < 9)  cmd = CMD_RELEASE;
    else if (r < 14) cmd = CMD_PEER_REQ;
    else             cmd = CMD_PEER_REPLY;
    lk  = pick_lock();
    src = ($urandom_range(0, 1) != 0) ? pick_peer() : NODE_W'($urandom_range(0, 7));
    seq = ($urandom_range(0, 1) != 0) ? pick_seq(lk) : SEQ_W'($urandom);
    fire(cmd, lk, src, seq);
  endtask

  always @(posedge clk) begin
    lock_msg_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d to %0d lock %0d",
                                  result_bus.out_kind, result_bus.to_node, result_bus.out_lock));
      end else begin
        want = expected_results.pop_front();
        if (result_bus.out_kind !== want.kind)
          report_mismatch($sformatf("out_kind got %0d want %0d", result_bus.out_kind, want.kind));
        if (result_bus.to_node !== want.dst)
          report_mismatch($sformatf("to_node got %0d want %0d", result_bus.to_node, want.dst));
        if (result_bus.out_lock !== want.lk)
          report_mismatch($sformatf("out_lock got %0d want %0d", result_bus.out_lock, want.lk));
        if (result_bus.out_seq !== want.seq)
          report_mismatch($sformatf("out_seq got %h want %h", result_bus.out_seq, want.seq));
        if (result_bus.last !== want.last)
          report_mismatch($sformatf("last got %b want %b", result_bus.last, want.last));
      end
    end
    if (stall_left > 0) begin
      result_bus.ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      result_bus.ready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  initial begin
    stim_row_t rows[$];
    int target;
    int phase;
    logic [NODE_COUNT-1:0] mask;

    rst                 <= 1'b1;
    item_bus.valid      <= 1'b0;
    item_bus.cmd        <= CMD_INIT;
    item_bus.lock_id    <= '0;
    item_bus.from_node  <= '0;
    item_bus.seq_number <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= REG_OWN_NODE_ID;
    cfg_bus.data        <= '0;
    node_id     = '0;
    member_mask = '0;
    for (int l = 0; l < LOCKS; l++) clear_lock(l);

    // After reset the peer set is empty: acquire grants at once
    rows = {rows, ev_row(ROW_ONE,  CMD_ACQUIRE, 4'd0, 3'd0, '0, KIND_GRANT, 3'd0)};
    rows = {rows, ev_row(ROW_NONE, CMD_ACQUIRE, 4'd0, 3'd0, '0, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_NONE, CMD_RELEASE, 4'd0, 3'd0, '0, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_NONE, CMD_UNUSED_LO, 4'd1, 3'd7, SEQ_TOP, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_NONE, CMD_UNUSED_HI, 4'd1, 3'd0, '0, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_NONE, CMD_PEER_REQ, 4'd2, 3'd1, 32'd10, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_NONE, CMD_RELEASE, 4'd15, 3'd0, '0, KIND_REQUEST, '0)};
    // Node 7 with every other node as peer
    rows = {rows, cfg_row(3'd7, 8'hFF)};
    rows = {rows, ev_row(ROW_ONE,  CMD_PEER_REQ, 4'd3, 3'd0, SEQ_TOP, KIND_REPLY, 3'd0)};
    rows = {rows, ev_row(ROW_PRED, CMD_ACQUIRE, 4'd3, 3'd0, '0, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_NONE, CMD_PEER_REQ, 4'd3, 3'd7, '0, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_ONE,  CMD_PEER_REQ, 4'd3, 3'd2, SEQ_TOP, KIND_REPLY, 3'd2)};
    rows = {rows, ev_row(ROW_ONE,  CMD_PEER_REQ, 4'd3, 3'd1, '0, KIND_REPLY, 3'd1)};
    for (int i = 0; i < 6; i++)
      rows = {rows, ev_row(ROW_NONE, CMD_PEER_REPLY, 4'd3, NODE_W'(i), '0, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_ONE,  CMD_PEER_REPLY, 4'd3, 3'd6, '0, KIND_GRANT, 3'd0)};
    rows = {rows, ev_row(ROW_NONE, CMD_PEER_REQ, 4'd3, 3'd3, '0, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_ONE,  CMD_RELEASE, 4'd3, 3'd0, '0, KIND_REPLY, 3'd3)};
    rows = {rows, ev_row(ROW_NONE, CMD_PEER_REPLY, 4'd4, 3'd1, '0, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_PRED, CMD_ACQUIRE, 4'd5, 3'd0, '0, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_NONE, CMD_PEER_REQ, 4'd5, 3'd2, 32'd9, KIND_REQUEST, '0)};
    rows = {rows, ev_row(ROW_NONE, CMD_INIT, 4'd5, 3'd0, '0, KIND_REQUEST, '0)};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].mode == ROW_CFG) begin
        wait_idle();
        set_config(rows[i].id, rows[i].mask);
      end else begin
        send_item(rows[i]);
      end
    end

    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      calm = 1'b0;
      wait_idle();
      case (phase)
        0: set_config(3'd0, 8'hFF);
        1: set_config(3'd7, 8'h01);
        2: set_config(3'd5, 8'h20);
        default: begin
          if ($urandom_range(0, 2) == 0) mask = NODE_COUNT'(1) << $urandom_range(0, 7);
          else mask = NODE_COUNT'($urandom_range(0, 255));
          set_config(NODE_W'($urandom_range(0, 7)), mask);
        end
      endcase
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) < 6) run_round();
        else send_noise();
      end
      phase++;
    end

    calm = 1'b0;
    wait_idle();
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
